// ----- src/pte_pkg.sv -----
// Shared types and constants of the piece table edit engine.
// No dependencies.
package pte_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned POS_W    = 14;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned READ_MAX = 64;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_LOAD   = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  // Per-cell controls: clear wins over shift, shift over load.
  typedef struct packed {
    logic clear;
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

// ----- src/pte_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pte_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/pte_cell.sv -----
// One slot of the piece chain: source, offset and length of one piece.
// Depends on pte_pkg for the control struct.
module pte_cell #(
  parameter int unsigned OffW = 12,
  parameter int unsigned LenW = 13
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pte_pkg::cell_ctl_t    ctl_i,
  input  logic                  shift_src_i,
  input  logic [OffW-1:0]       shift_off_i,
  input  logic [LenW-1:0]       shift_len_i,
  input  logic [LenW-1:0]       load_len_i,
  output logic                  src_o,
  output logic [OffW-1:0]       off_o,
  output logic [LenW-1:0]       len_o
);

  logic            src_q;
  logic [OffW-1:0] off_q;
  logic [LenW-1:0] len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= 1'b0;
      off_q <= '0;
      len_q <= '0;
    end else if (ctl_i.clear) begin
      src_q <= 1'b0;
      off_q <= '0;
      len_q <= '0;
    end else if (ctl_i.shift) begin
      src_q <= shift_src_i;
      off_q <= shift_off_i;
      len_q <= shift_len_i;
    end else if (ctl_i.load) begin
      // load of original text: the piece always covers all original bytes loaded so far
      src_q <= 1'b0;
      off_q <= '0;
      len_q <= load_len_i;
    end
  end

  assign src_o = src_q;
  assign off_o = off_q;
  assign len_o = len_q;

endmodule

// ----- src/piece_table_edit_engine.sv -----
// Piece table edit engine, top level: controller, piece chain and both stores.
// Depends on pte_pkg, pte_cell and pte_ram.
//
// Usage:
//   An item (op, position, char_in, read_count) is taken on a rising edge with
//   start_i high and busy_o low. Every result is shown for exactly one cycle
//   with result_valid_o high; the receiver cannot hold results off.
//   Clear, load, a read that yields no bytes, and an insert or delete refused
//   on its position or on a full append store answer in the cycle after the
//   item is taken, and busy_o stays low, so items may follow back to back.
//   Insert and delete rotate the whole piece chain once through the head
//   cell; the result comes in the cycle after the last shift. The controller
//   inspects the head piece each cycle and rewrites it, splits it (up to two
//   extra pieces held in a small queue) or drops it (the chain then feeds
//   from the second cell for the rest of the rotation). A full piece table
//   is found during the rotation, so that refusal comes late too.
//   A read also rotates the chain once; while a piece holds bytes the chain
//   stalls and one byte a cycle is fetched from the store RAM. Bytes come
//   one per cycle except for a gap at each empty piece, with last_o on the
//   final one. text_length_o shows the length after the op.
//   Reset empties the table (one empty piece); the stores are not cleared
//   and need no sweep.
module piece_table_edit_engine #(
  parameter int unsigned MAX_PIECES     = 64,
  parameter int unsigned ORIGINAL_DEPTH = 4096,
  parameter int unsigned APPEND_DEPTH   = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  op_i,
  input  logic [13:0] position_i,
  input  logic [7:0]  char_in_i,
  input  logic [6:0]  read_count_i,
  output logic        result_valid_o,
  output logic        ok_o,
  output logic [7:0]  char_out_o,
  output logic        char_valid_o,
  output logic        last_o,
  output logic [13:0] text_length_o
);

  localparam int unsigned MaxD  = (ORIGINAL_DEPTH > APPEND_DEPTH) ? ORIGINAL_DEPTH
                                                                   : APPEND_DEPTH;
  localparam int unsigned OffW  = $clog2(MaxD);
  localparam int unsigned LenW  = $clog2(MaxD + 1);
  localparam int unsigned OAw   = $clog2(ORIGINAL_DEPTH);
  localparam int unsigned AAw   = $clog2(APPEND_DEPTH);
  localparam int unsigned OuW   = $clog2(ORIGINAL_DEPTH + 1);
  localparam int unsigned AuW   = $clog2(APPEND_DEPTH + 1);
  localparam int unsigned TotW  = $clog2(ORIGINAL_DEPTH + APPEND_DEPTH + 1);
  localparam int unsigned PosW  = pte_pkg::POS_W;
  localparam int unsigned CntW  = pte_pkg::CNT_W;
  localparam int unsigned WW    = ((TotW > PosW) ? TotW : PosW) + 1;
  localparam int unsigned SW    = $clog2(MAX_PIECES);
  localparam int unsigned CW    = $clog2(MAX_PIECES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EDIT,
    ST_READ
  } state_e;

  // ---------------- registers ----------------
  state_e           state_q, state_d;
  logic [SW-1:0]    step_q, step_d;
  logic [WW-1:0]    ls_q, ls_d;
  logic             found_q, found_d;
  logic             look_q, look_d;
  logic             q0v_q, q0v_d, q1v_q, q1v_d;
  logic             q0s_q, q0s_d, q1s_q, q1s_d;
  logic [OffW-1:0]  q0o_q, q0o_d, q1o_q, q1o_d;
  logic [LenW-1:0]  q0l_q, q0l_d, q1l_q, q1l_d;
  logic [CW-1:0]    count_q, count_d, pend_q, pend_d;
  logic [TotW-1:0]  total_q, total_d;
  logic [OuW-1:0]   ou_q, ou_d;
  logic [AuW-1:0]   au_q, au_d;
  logic             edited_q, edited_d;
  pte_pkg::op_e     op_q, op_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [pte_pkg::CHAR_W-1:0] ch_q, ch_d;
  logic             acc_q, acc_d;
  logic [WW-1:0]    rdpos_q, rdpos_d;
  logic [CntW-1:0]  k_q, k_d, n_q, n_d;
  logic             rv_q, rv_d, rok_q, rok_d, rcv_q, rcv_d, rlast_q, rlast_d;
  logic             rsrc_q, rsrc_d;

  // ---------------- chain ----------------
  logic             c_src [MAX_PIECES];
  logic [OffW-1:0]  c_off [MAX_PIECES];
  logic [LenW-1:0]  c_len [MAX_PIECES];
  logic             tail_src;
  logic [OffW-1:0]  tail_off;
  logic [LenW-1:0]  tail_len;
  logic             clr, sh, ld;
  logic [LenW-1:0]  ld_len;

  for (genvar k = 0; k < MAX_PIECES; k++) begin : g_cell
    localparam bit IsHead = (k == 0);
    pte_pkg::cell_ctl_t ctl;
    logic               ns;
    logic [OffW-1:0]    no;
    logic [LenW-1:0]    nl;
    if (k == MAX_PIECES - 1) begin : g_tail
      assign ns = tail_src;
      assign no = tail_off;
      assign nl = tail_len;
    end else begin : g_link
      assign ns = c_src[k+1];
      assign no = c_off[k+1];
      assign nl = c_len[k+1];
    end
    assign ctl.clear = clr;
    assign ctl.shift = sh;
    assign ctl.load  = ld & IsHead;
    pte_cell #(.OffW(OffW), .LenW(LenW)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .shift_src_i (ns),
      .shift_off_i (no),
      .shift_len_i (nl),
      .load_len_i  (ld_len),
      .src_o       (c_src[k]),
      .off_o       (c_off[k]),
      .len_o       (c_len[k])
    );
  end

  // ---------------- stores ----------------
  logic            ow_en, aw_en;
  logic [OffW-1:0] rd_addr;
  logic [7:0]      o_rdata, a_rdata;

  pte_ram #(.Width(8), .Depth(ORIGINAL_DEPTH)) u_orig (
    .clk_i   (clk_i),
    .we_i    (ow_en),
    .waddr_i (ou_q[OAw-1:0]),
    .wdata_i (ch_d),
    .raddr_i (rd_addr[OAw-1:0]),
    .rdata_o (o_rdata)
  );

  pte_ram #(.Width(8), .Depth(APPEND_DEPTH)) u_app (
    .clk_i   (clk_i),
    .we_i    (aw_en),
    .waddr_i (au_q[AAw-1:0]),
    .wdata_i (ch_q),
    .raddr_i (rd_addr[AAw-1:0]),
    .rdata_o (a_rdata)
  );

  // ---------------- control ----------------
  logic [WW-1:0]   posx, totx, end_sum, head, avail;
  logic [CW:0]     cx, need;
  logic            in_src;
  logic [OffW-1:0] in_off;
  logic [LenW-1:0] in_len;
  logic            in_ok, hit, last_step;
  logic [CntW-1:0] cnt_sat;

  always_comb begin
    state_d  = state_q;   step_d  = step_q;   ls_d    = ls_q;
    found_d  = found_q;   look_d  = look_q;
    q0v_d = q0v_q; q0s_d = q0s_q; q0o_d = q0o_q; q0l_d = q0l_q;
    q1v_d = q1v_q; q1s_d = q1s_q; q1o_d = q1o_q; q1l_d = q1l_q;
    count_d  = count_q;   pend_d  = pend_q;   total_d = total_q;
    ou_d     = ou_q;      au_d    = au_q;     edited_d = edited_q;
    op_d     = op_q;      pos_d   = pos_q;    ch_d    = ch_q;
    acc_d    = acc_q;     rdpos_d = rdpos_q;  k_d     = k_q;  n_d = n_q;
    rv_d = 1'b0; rok_d = rok_q; rcv_d = 1'b0; rlast_d = rlast_q; rsrc_d = rsrc_q;
    clr = 1'b0; sh = 1'b0; ld = 1'b0; ow_en = 1'b0; aw_en = 1'b0;
    ld_len   = LenW'(ou_q) + LenW'(1);
    tail_src = c_src[0]; tail_off = c_off[0]; tail_len = c_len[0];
    rd_addr  = '0;
    need     = '0;
    head     = '0;
    posx     = WW'(pos_q);
    totx     = WW'(total_q);
    end_sum  = ls_q + WW'(c_len[0]);
    cx       = (CW+1)'(count_q);
    last_step = (step_q == SW'(MAX_PIECES - 1));
    in_src = look_q ? c_src[1] : c_src[0];
    in_off = look_q ? c_off[1] : c_off[0];
    in_len = look_q ? c_len[1] : c_len[0];
    in_ok  = look_q ? ((CW+1)'(step_q) + (CW+1)'(1) < cx) : ((CW+1)'(step_q) < cx);
    hit    = 1'b0;
    avail  = '0;
    cnt_sat = (read_count_i > CntW'(pte_pkg::READ_MAX)) ? CntW'(pte_pkg::READ_MAX)
                                                        : read_count_i;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d    = pte_pkg::op_e'(op_i);
          pos_d   = position_i;
          ch_d    = char_in_i;
          posx    = WW'(position_i);
          rv_d    = 1'b1;
          rok_d   = 1'b0;
          rlast_d = 1'b1;
          avail   = totx - posx;
          unique case (pte_pkg::op_e'(op_i)) inside
            pte_pkg::OP_CLEAR: begin
              clr = 1'b1; count_d = CW'(1); ou_d = '0; au_d = '0;
              total_d = '0; edited_d = 1'b0; rok_d = 1'b1;
            end
            pte_pkg::OP_LOAD: begin
              if (!edited_q && (ou_q < OuW'(ORIGINAL_DEPTH))) begin
                ow_en = 1'b1; ld = 1'b1;
                ou_d = ou_q + OuW'(1);
                total_d = total_q + TotW'(1);
                rok_d = 1'b1;
              end
            end
            pte_pkg::OP_INSERT, pte_pkg::OP_DELETE: begin
              if ((pte_pkg::op_e'(op_i) == pte_pkg::OP_INSERT)
                  ? (posx <= totx && au_q < AuW'(APPEND_DEPTH)) : (posx < totx)) begin
                rv_d = 1'b0; state_d = ST_EDIT; step_d = '0; ls_d = '0;
                found_d = 1'b0; look_d = 1'b0; q0v_d = 1'b0; q1v_d = 1'b0;
                acc_d = 1'b0; pend_d = count_q;
              end
            end
            pte_pkg::OP_READ: begin
              if (posx <= totx) begin
                rok_d = 1'b1;
                n_d = (avail < WW'(cnt_sat)) ? CntW'(avail) : cnt_sat;
                if (n_d != '0) begin
                  rv_d = 1'b0; state_d = ST_READ; step_d = '0; ls_d = '0;
                  rdpos_d = posx; k_d = '0;
                end
              end
            end
            default: ;
          endcase
        end
      end

      ST_EDIT: begin
        sh     = 1'b1;
        step_d = step_q + SW'(1);
        ls_d   = end_sum;
        // normal flow: queued pieces go out first, incoming joins the queue
        tail_src = in_src; tail_off = in_off; tail_len = in_len;
        if (q0v_q) begin
          tail_src = q0s_q; tail_off = q0o_q; tail_len = q0l_q;
          if (in_ok) begin
            if (q1v_q) begin
              q0s_d = q1s_q; q0o_d = q1o_q; q0l_d = q1l_q;
              q1s_d = in_src; q1o_d = in_off; q1l_d = in_len;
            end else begin
              q0s_d = in_src; q0o_d = in_off; q0l_d = in_len;
            end
          end else begin
            q0v_d = q1v_q; q0s_d = q1s_q; q0o_d = q1o_q; q0l_d = q1l_q;
            q1v_d = 1'b0;
          end
        end
        hit = !found_q && ((CW+1)'(step_q) < cx) &&
              ((op_q == pte_pkg::OP_INSERT) ? (posx <= end_sum) : (posx < end_sum));
        head = posx - ls_q;
        if (hit) begin
          found_d = 1'b1;
          if (op_q == pte_pkg::OP_INSERT) begin
            if (posx == ls_q) begin
              need = (CW+1)'(1);
            end else if (posx == end_sum) begin
              need = (c_src[0] && (WW'(c_off[0]) + WW'(c_len[0]) == WW'(au_q)))
                     ? '0 : (CW+1)'(1);
            end else begin
              need = (CW+1)'(2);
            end
            if (cx + need <= (CW+1)'(MAX_PIECES)) begin
              acc_d  = 1'b1;
              aw_en  = 1'b1;
              pend_d = CW'(cx + need);
              if (posx == ls_q) begin
                tail_src = 1'b1; tail_off = OffW'(au_q); tail_len = LenW'(1);
                q0v_d = 1'b1; q0s_d = c_src[0]; q0o_d = c_off[0]; q0l_d = c_len[0];
              end else if (need == '0) begin
                tail_len = c_len[0] + LenW'(1);
              end else if (posx == end_sum) begin
                q0v_d = 1'b1; q0s_d = 1'b1; q0o_d = OffW'(au_q); q0l_d = LenW'(1);
              end else begin
                tail_len = LenW'(head);
                q0v_d = 1'b1; q0s_d = 1'b1; q0o_d = OffW'(au_q); q0l_d = LenW'(1);
                q1v_d = 1'b1; q1s_d = c_src[0];
                q1o_d = c_off[0] + OffW'(head);
                q1l_d = c_len[0] - LenW'(head);
              end
            end
          end else begin
            if (posx == ls_q || posx == end_sum - WW'(1)) begin
              acc_d = 1'b1;
              if (c_len[0] == LenW'(1) && count_q != CW'(1)) begin
                // piece vanishes: feed the chain from the next cell from now on
                look_d = 1'b1;
                tail_src = c_src[1]; tail_off = c_off[1]; tail_len = c_len[1];
                pend_d = count_q - CW'(1);
              end else begin
                tail_off = c_off[0] + ((posx == ls_q) ? OffW'(1) : '0);
                tail_len = c_len[0] - LenW'(1);
              end
            end else if (count_q < CW'(MAX_PIECES)) begin
              acc_d  = 1'b1;
              pend_d = count_q + CW'(1);
              tail_len = LenW'(head);
              q0v_d = 1'b1; q0s_d = c_src[0];
              q0o_d = c_off[0] + OffW'(head) + OffW'(1);
              q0l_d = c_len[0] - LenW'(head) - LenW'(1);
            end
          end
        end
        if (last_step) begin
          state_d = ST_IDLE;
          rv_d = 1'b1; rok_d = acc_d; rlast_d = 1'b1;
          if (acc_d) begin
            count_d  = pend_d;
            edited_d = 1'b1;
            if (op_q == pte_pkg::OP_INSERT) begin
              total_d = total_q + TotW'(1);
              au_d    = au_q + AuW'(1);
            end else begin
              total_d = total_q - TotW'(1);
            end
          end
        end
      end

      ST_READ: begin
        hit = ((CW+1)'(step_q) < cx) && (rdpos_q < end_sum) && (k_q < n_q);
        rd_addr = c_off[0] + OffW'(rdpos_q - ls_q);
        sh = !hit || (rdpos_q + WW'(1) == end_sum);
        if (hit) begin
          rdpos_d = rdpos_q + WW'(1);
          k_d     = k_q + CntW'(1);
          rv_d = 1'b1; rok_d = 1'b1; rcv_d = 1'b1;
          rlast_d = (k_q + CntW'(1) == n_q);
          rsrc_d  = c_src[0];
        end
        if (sh) begin
          step_d = step_q + SW'(1);
          ls_d   = end_sum;
          if (last_step) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;  step_q <= '0;  ls_q <= '0;  found_q <= 1'b0;  look_q <= 1'b0;
      q0v_q <= 1'b0;  q1v_q <= 1'b0;
      count_q <= CW'(1);  pend_q <= CW'(1);  total_q <= '0;
      ou_q <= '0;  au_q <= '0;  edited_q <= 1'b0;
      op_q <= pte_pkg::OP_CLEAR;  acc_q <= 1'b0;
      k_q <= '0;  n_q <= '0;
      rv_q <= 1'b0;  rok_q <= 1'b0;  rcv_q <= 1'b0;  rlast_q <= 1'b0;  rsrc_q <= 1'b0;
    end else begin
      state_q <= state_d;  step_q <= step_d;  ls_q <= ls_d;
      found_q <= found_d;  look_q <= look_d;
      q0v_q <= q0v_d;  q1v_q <= q1v_d;
      count_q <= count_d;  pend_q <= pend_d;  total_q <= total_d;
      ou_q <= ou_d;  au_q <= au_d;  edited_q <= edited_d;
      op_q <= op_d;  acc_q <= acc_d;
      k_q <= k_d;  n_q <= n_d;
      rv_q <= rv_d;  rok_q <= rok_d;  rcv_q <= rcv_d;  rlast_q <= rlast_d;  rsrc_q <= rsrc_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    q0s_q <= q0s_d;  q0o_q <= q0o_d;  q0l_q <= q0l_d;
    q1s_q <= q1s_d;  q1o_q <= q1o_d;  q1l_q <= q1l_d;
    pos_q <= pos_d;  ch_q <= ch_d;  rdpos_q <= rdpos_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = rv_q;
  assign ok_o           = rok_q;
  assign char_valid_o   = rcv_q;
  assign last_o         = rlast_q;
  assign char_out_o     = rcv_q ? (rsrc_q ? a_rdata : o_rdata) : 8'd0;
  assign text_length_o  = PosW'(total_q);

endmodule
